[rtl/dlr_pkg.sv]
// Shared types, field widths and constants of the distance-to-light ramp block.
package dlr_pkg;

    // Field widths fixed by the item formats
    localparam int DIST_W    = 12;
    localparam int LVL_W     = 8;
    localparam int GREEN_W   = 7;
    localparam int BLUE_W    = 5;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;
    localparam int M_FIELD_W = 2 * LVL_W + GREEN_W + BLUE_W;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;

    // Defaults for the top-level parameters
    localparam int MAP_STEPS_DEF      = 64;
    localparam int LEVEL_MAX_DEF      = 255;
    localparam int DISTANCE_FLOOR_DEF = 30;
    localparam int ACCEPT_MARGIN_DEF  = 25;

    localparam logic [DIST_W-1:0] DIST_MAX_RESET = 12'd200;

    // Item kinds carried on s_tuser
    localparam logic ACT_MEASURE = 1'b0;
    localparam logic ACT_TICK    = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK,
        ST_CHECK,
        ST_DIV_MAP,
        ST_MAP_DONE,
        ST_SQUARE,
        ST_SCALE,
        ST_RECIP,
        ST_TARGET
    } dlr_state_t;

    typedef struct packed {
        logic capture;
        logic div_load;
        logic recip;
        logic div_step;
        logic x_from_div;
        logic x_direct;
        logic square;
        logic scale;
        logic target_wr;
        logic tick_step;
    } dlr_cmd_t;

    typedef struct packed {
        logic meas_ok;
        logic map_direct;
        logic div_last;
        logic level_eq;
        logic out_free;
    } dlr_stat_t;

endpackage

[rtl/dlr_div.sv]
// Restoring divider: one quotient bit per cycle in which step is high, used for the distance mapping.
module dlr_div
    import dlr_pkg::*;
#(
    parameter int W = 22
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         load,
    input  logic         step,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic [W-1:0] quo,
    output logic         last
);

    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W:0]       trial;
    logic [W:0]       diff;
    logic             fits;

    always_comb begin
        trial = {rem_reg, quo_reg[W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});
        if (fits) begin
            rem_next = diff[W-1:0];
            quo_next = {quo_reg[W-2:0], 1'b1};
        end else begin
            rem_next = trial[W-1:0];
            quo_next = {quo_reg[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (load) begin
            cnt_reg <= '0;
        end else if (step) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end else if (step) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quo  = quo_reg;
    assign last = (cnt_reg == CNT_W'(W - 1));

endmodule

[rtl/dlr_datapath.sv]
// Datapath: calibration register, distance mapping, level ramp and output register.
module dlr_datapath
    import dlr_pkg::*;
#(
    parameter int MAP_STEPS      = MAP_STEPS_DEF,
    parameter int LEVEL_MAX      = LEVEL_MAX_DEF,
    parameter int DISTANCE_FLOOR = DISTANCE_FLOOR_DEF,
    parameter int ACCEPT_MARGIN  = ACCEPT_MARGIN_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dlr_cmd_t              cmd,
    input  logic [DIST_W-1:0]     in_distance,
    input  logic                  cfg_wr_en,
    input  logic [DIST_W-1:0]     cfg_wr_data,
    input  logic                  m_tready,
    output dlr_stat_t             stat,
    output logic                  m_tvalid,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast
);

    localparam int MAP_W    = $clog2(MAP_STEPS + 1);
    localparam int NUM1_W   = DIST_W + MAP_W;
    localparam int SQ_W     = 2 * MAP_W;
    localparam int NUM2_W   = SQ_W + LVL_W;
    localparam int DIV_W    = NUM1_W;
    localparam int ACC_W    = $clog2((1 << DIST_W) + ACCEPT_MARGIN);
    localparam int STEPS_SQ = MAP_STEPS * MAP_STEPS;
    localparam int SCALE_SH = NUM2_W + SQ_W;
    localparam int RCP_W    = NUM2_W + 3;
    localparam int PROD_W   = NUM2_W + RCP_W;
    localparam int QSC_W    = PROD_W - SCALE_SH;
    localparam logic [RCP_W-1:0] SCALE_RCP =
        RCP_W'(((64'd1 << SCALE_SH) + 64'(STEPS_SQ) - 64'd1) / 64'(STEPS_SQ));
    localparam int D10_W    = 16;
    localparam int D10_MUL  = 205;
    localparam int D10_SH   = 11;

    logic [DIST_W-1:0]  dmax_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic [MAP_W-1:0]   x_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic [NUM2_W-1:0]  prod_reg;
    logic [QSC_W-1:0]   lvl_reg;
    logic [LVL_W-1:0]   cur_reg;
    logic [LVL_W-1:0]   tgt_reg;
    logic               valid_reg;
    logic [LVL_W-1:0]   red_reg;
    logic [GREEN_W-1:0] green_reg;
    logic [BLUE_W-1:0]  blue_reg;
    logic               last_reg;

    logic               dmax_low;
    logic               dist_low;
    logic [MAP_W-1:0]   x_direct_val;
    logic [NUM1_W-1:0]  num1;
    logic [DIV_W-1:0]   div_num;
    logic [DIV_W-1:0]   div_den;
    logic [DIV_W-1:0]   div_quo;
    logic               div_last;
    logic [PROD_W-1:0]  rcp_prod;
    logic [LVL_W-1:0]   lv_next;
    logic [GREEN_W-1:0] green_next;
    logic [BLUE_W-1:0]  blue_next;
    logic [D10_W-1:0]   d10_prod;
    logic               out_free;

    // Mapping operands
    assign dmax_low     = (dmax_reg <= DIST_W'(DISTANCE_FLOOR));
    assign dist_low     = (dist_reg <= DIST_W'(DISTANCE_FLOOR));
    assign x_direct_val = (dmax_low && !dist_low) ? MAP_W'(MAP_STEPS) : '0;
    assign num1         = NUM1_W'(dist_reg - DIST_W'(DISTANCE_FLOOR)) * NUM1_W'(MAP_STEPS);

    assign div_num = DIV_W'(num1);
    assign div_den = DIV_W'(dmax_reg - DIST_W'(DISTANCE_FLOOR));

    dlr_div #(
        .W (DIV_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (cmd.div_load),
        .step    (cmd.div_step),
        .num     (div_num),
        .den     (div_den),
        .quo     (div_quo),
        .last    (div_last)
    );

    // Divide by MAP_STEPS^2 as multiply-shift; the reciprocal is rounded up and
    // wide enough to give the truncated quotient for every scaled square
    assign rcp_prod = PROD_W'(prod_reg) * PROD_W'(SCALE_RCP);

    // Next ramp step and its color channels; level / 10 as multiply-shift
    always_comb begin
        if (tgt_reg > cur_reg) begin
            lv_next = cur_reg + 1'b1;
        end else begin
            lv_next = cur_reg - 1'b1;
        end
        if (lv_next == '0) begin
            green_next = '0;
        end else if (lv_next[LVL_W-1:1] == '0) begin
            green_next = GREEN_W'(1);
        end else begin
            green_next = lv_next[LVL_W-1:1];
        end
        d10_prod = D10_W'(lv_next) * D10_W'(D10_MUL);
        if (lv_next > LVL_W'(9)) begin
            blue_next = d10_prod[D10_SH+BLUE_W-1:D10_SH];
        end else begin
            blue_next = '0;
        end
    end

    assign out_free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dmax_reg  <= DIST_MAX_RESET;
            cur_reg   <= '0;
            tgt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                dmax_reg <= cfg_wr_data;
            end
            if (cmd.target_wr) begin
                tgt_reg <= (lvl_reg > QSC_W'(LEVEL_MAX)) ? LVL_W'(LEVEL_MAX)
                         : lvl_reg[LVL_W-1:0];
            end
            if (cmd.tick_step) begin
                cur_reg   <= lv_next;
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            dist_reg <= in_distance;
        end
        if (cmd.x_direct) begin
            x_reg <= x_direct_val;
        end else if (cmd.x_from_div) begin
            x_reg <= (div_quo > DIV_W'(MAP_STEPS)) ? MAP_W'(MAP_STEPS) : div_quo[MAP_W-1:0];
        end
        if (cmd.square) begin
            sq_reg <= SQ_W'(x_reg) * SQ_W'(x_reg);
        end
        if (cmd.scale) begin
            prod_reg <= NUM2_W'(sq_reg) * NUM2_W'(LEVEL_MAX);
        end
        if (cmd.recip) begin
            lvl_reg <= rcp_prod[PROD_W-1:SCALE_SH];
        end
        if (cmd.tick_step) begin
            red_reg   <= lv_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            last_reg  <= (lv_next == tgt_reg);
        end
    end

    always_comb begin
        stat.meas_ok    = (dist_reg != '0) &&
                          (ACC_W'(dist_reg) <= ACC_W'(dmax_reg) + ACC_W'(ACCEPT_MARGIN));
        stat.map_direct = dmax_low || dist_low;
        stat.div_last   = div_last;
        stat.level_eq   = (cur_reg == tgt_reg);
        stat.out_free   = out_free;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, red_reg, blue_reg, green_reg, red_reg};
    assign m_tlast  = last_reg;

endmodule

[rtl/dlr_ctrl.sv]
// Controller: sequences each item through the datapath.
module dlr_ctrl
    import dlr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    input  logic      s_tuser,
    input  dlr_stat_t stat,
    output logic      s_tready,
    output dlr_cmd_t  cmd
);

    dlr_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = (s_tuser == ACT_TICK) ? ST_TICK : ST_CHECK;
                end
            end
            ST_TICK: begin
                // leave when the level is at the target, else hold until the output register can take the step
                if (stat.level_eq) begin
                    state_next = ST_IDLE;
                end else if (stat.out_free) begin
                    cmd.tick_step = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_CHECK: begin
                if (!stat.meas_ok) begin
                    state_next = ST_IDLE;
                end else if (stat.map_direct) begin
                    cmd.x_direct = 1'b1;
                    state_next   = ST_SQUARE;
                end else begin
                    cmd.div_load = 1'b1;
                    state_next   = ST_DIV_MAP;
                end
            end
            ST_DIV_MAP: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_MAP_DONE;
                end
            end
            ST_MAP_DONE: begin
                cmd.x_from_div = 1'b1;
                state_next     = ST_SQUARE;
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_RECIP;
            end
            ST_RECIP: begin
                cmd.recip  = 1'b1;
                state_next = ST_TARGET;
            end
            ST_TARGET: begin
                cmd.target_wr = 1'b1;
                state_next    = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/distance_to_light_ramp.sv]
// Top level of the distance-to-light ramp block: controller, datapath, port checks.
//
// Turns distance measurements into a target brightness and ramps a kept level toward it,
// one step per tick item. A measurement item (s_tuser = 0) with a nonzero distance no
// greater than distance_max + ACCEPT_MARGIN maps the distance linearly from
// DISTANCE_FLOOR..distance_max onto 0..MAP_STEPS (truncated, clamped), squares it and
// scales it to 0..LEVEL_MAX; it never gives a result. A tick item (s_tuser = 1) moves the
// level one step toward the target and gives one result item with red = level,
// green = level/2 (at least 1 when nonzero), blue = level/10 above 9, and m_tlast set when
// the target is reached; a tick with the level already at the target gives nothing.
// Items are handled one at a time. A tick goes through ST_TICK back to idle and waits there
// while an earlier result still waits on m_tready. A measurement runs the mapping division
// through a restoring divider, one quotient bit per cycle, and scales the square by a
// constant reciprocal multiply; the divider is DIV_W = 19 bits wide with the default
// parameters. A rejected one goes straight back to idle, and one that needs no division
// (distance or distance_max at or below the floor) skips the divider. The result register
// lets a measurement be taken while a result waits. The user writes distance_max through
// cfg_wr_en/cfg_wr_data only while the block is idle; the block does not enforce this.
module distance_to_light_ramp
    import dlr_pkg::*;
#(
    parameter int MAP_STEPS      = MAP_STEPS_DEF,
    parameter int LEVEL_MAX      = LEVEL_MAX_DEF,
    parameter int DISTANCE_FLOOR = DISTANCE_FLOOR_DEF,
    parameter int ACCEPT_MARGIN  = ACCEPT_MARGIN_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input item channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [11:0] distance_mm, [15:12] zero
    input  logic                 s_tuser,   // action: 0 measurement, 1 ramp tick
    // result item channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] red, [14:8] green, [19:15] blue,
                                            // [27:20] level, [31:28] zero
    output logic                 m_tlast,   // ramp_last
    // calibration register distance_max
    input  logic                 cfg_wr_en,
    input  logic [DIST_W-1:0]    cfg_wr_data
);

    dlr_cmd_t  cmd;
    dlr_stat_t stat;

    // Sequence measurements and ticks, issue one command set per cycle
    dlr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    // Hold calibration, level state, mapping arithmetic and the result register
    dlr_datapath #(
        .MAP_STEPS      (MAP_STEPS),
        .LEVEL_MAX      (LEVEL_MAX),
        .DISTANCE_FLOOR (DISTANCE_FLOOR),
        .ACCEPT_MARGIN  (ACCEPT_MARGIN)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .in_distance (s_tdata[DIST_W-1:0]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tready    (m_tready),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    // A step must never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.tick_step |-> (!m_tvalid || m_tready))
        else $error("ramp step loaded over a pending result item");

    // A step always shows up as a result item in the next cycle
    a_step_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.tick_step |=> m_tvalid)
        else $error("ramp step did not produce a result item");

    // One item at a time: an accepted item closes the input until its work is done
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input reopened in the cycle after an accepted item");

endmodule

[bench/dlr_ramp_checker.sv]
// Checker for the distance-to-light ramp block: predicts each color step and compares it.
module dlr_ramp_checker
    import dlr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [11:0] distance_mm, [15:12] zero
    input  logic                 s_tuser,   // action
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // [7:0] red, [14:8] green, [19:15] blue,
                                            // [27:20] level, [31:28] zero
    input  logic                 m_tlast,   // ramp_last
    input  logic                 cfg_wr_en,
    input  logic [DIST_W-1:0]    cfg_wr_data,
    output int                   fail_count,
    output int                   colors_due
);

    typedef struct packed {
        logic [LVL_W-1:0]   red;
        logic [GREEN_W-1:0] green;
        logic [BLUE_W-1:0]  blue;
        logic [LVL_W-1:0]   level;
        logic               ramp_last;
    } color_step_t;

    color_step_t       color_queue[$];
    logic [DIST_W-1:0] dist_max;
    logic [LVL_W-1:0]  level_now;
    logic [LVL_W-1:0]  level_goal;

    // Map a distance onto 0..MAP_STEPS, square it and scale it to 0..LEVEL_MAX.
    function automatic logic [LVL_W-1:0] goal_for_distance(logic [DIST_W-1:0] dist_mm,
                                                           logic [DIST_W-1:0] dmax);
        int steps;
        int bright;
        if (int'(dmax) <= DISTANCE_FLOOR_DEF) begin
            steps = (int'(dist_mm) > DISTANCE_FLOOR_DEF) ? MAP_STEPS_DEF : 0;
        end else if (int'(dist_mm) <= DISTANCE_FLOOR_DEF) begin
            steps = 0;
        end else begin
            steps = (int'(dist_mm) - DISTANCE_FLOOR_DEF) * MAP_STEPS_DEF
                    / (int'(dmax) - DISTANCE_FLOOR_DEF);
            if (steps > MAP_STEPS_DEF)
                steps = MAP_STEPS_DEF;
        end
        bright = steps * steps * LEVEL_MAX_DEF / (MAP_STEPS_DEF * MAP_STEPS_DEF);
        if (bright > LEVEL_MAX_DEF)
            bright = LEVEL_MAX_DEF;
        return bright[LVL_W-1:0];
    endfunction

    function automatic color_step_t color_for_level(logic [LVL_W-1:0] lv, logic reached);
        color_step_t c;
        c.red       = lv;
        c.green     = (lv == 0) ? '0 : (lv < 2) ? GREEN_W'(1) : GREEN_W'(lv >> 1);
        c.blue      = (lv > 9) ? BLUE_W'(lv / 10) : '0;
        c.level     = lv;
        c.ramp_last = reached;
        return c;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : watch
        color_step_t got;
        color_step_t want;
        logic [DIST_W-1:0] dist_mm;
        if (!aresetn) begin
            dist_max   = DIST_MAX_RESET;
            level_now  = '0;
            level_goal = '0;
            fail_count = 0;
            color_queue.delete();
        end else begin
            // Results leave before this edge's input item can add one.
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[7:0], m_tdata[14:8], m_tdata[19:15], m_tdata[27:20], m_tlast};
                if (color_queue.size() == 0) begin
                    $display("%0t: unexpected color item: expected none, actual %h", $time, got);
                    fail_count++;
                end else begin
                    want = color_queue.pop_front();
                    check_field("red", want.red, got.red);
                    check_field("green", want.green, got.green);
                    check_field("blue", want.blue, got.blue);
                    check_field("level", want.level, got.level);
                    check_field("ramp_last", want.ramp_last, got.ramp_last);
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == ACT_MEASURE) begin
                    dist_mm = s_tdata[DIST_W-1:0];
                    if (dist_mm != 0 && int'(dist_mm) <= int'(dist_max) + ACCEPT_MARGIN_DEF)
                        level_goal = goal_for_distance(dist_mm, dist_max);
                end else if (level_now != level_goal) begin
                    level_now = (level_goal > level_now) ? level_now + 1'b1 : level_now - 1'b1;
                    color_queue.push_back(color_for_level(level_now, level_now == level_goal));
                end
            end
            if (cfg_wr_en)
                dist_max = cfg_wr_data;
        end
        colors_due = color_queue.size();
    end

endmodule

[bench/distance_to_light_ramp_tb.sv]
// Testbench top for the distance-to-light ramp block: stimulus, idling and verdict.
module distance_to_light_ramp_tb;
    import dlr_pkg::*;

    // Long enough for the longest measurement, with a comfortable margin on top.
    localparam int SETTLE_CYCLES = 64;
    localparam int PHASE_ITEMS   = 65;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;     // [11:0] distance_mm, [15:12] zero
    logic                 s_tuser;     // action: 0 measurement, 1 ramp tick
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;     // [7:0] red, [14:8] green, [19:15] blue,
                                       // [27:20] level, [31:28] zero
    logic                 m_tlast;     // ramp_last
    logic                 cfg_wr_en;
    logic [DIST_W-1:0]    cfg_wr_data;

    int                   fail_count;
    int                   colors_due;
    int                   items_sent;
    bit                   sender_burst;
    bit                   receiver_burst;
    logic [DIST_W-1:0]    last_dist;
    logic [DIST_W-1:0]    dmax_plan[8];

    distance_to_light_ramp uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    dlr_ramp_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .colors_due  (colors_due)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop: several times the slowest legal run.
    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Offer one item after a random gap and hold it until the block takes it.
    // Called and returning on a falling edge; tvalid stays high between
    // back-to-back items so it never toggles twice in one step.
    task automatic send_item(input logic act, input logic [DIST_W-1:0] dist_mm);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(S_TDATA_W-DIST_W){1'b0}}, dist_mm};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
    endtask

    // Drain all results, then let a measurement still in the divider finish
    // before touching the calibration register.
    task automatic write_distance_max(input logic [DIST_W-1:0] value);
        s_tvalid <= 1'b0;
        while (colors_due != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Pick an accepted distance: half the time a small nudge from the last one so that
    // ramps are short and settle, otherwise anywhere in the accepted window.
    function automatic logic [DIST_W-1:0] pick_distance(input logic [DIST_W-1:0] dmax);
        int span;
        int d;
        span = int'(dmax) + ACCEPT_MARGIN_DEF;
        if (span > 4095)
            span = 4095;
        if ($urandom_range(0, 9) < 5) begin
            d = int'(last_dist) + $urandom_range(0, 12) - 6;
            if (d < 1)
                d = 1;
            if (d > span)
                d = span;
        end else begin
            d = $urandom_range(1, span);
        end
        last_dist = d[DIST_W-1:0];
        return last_dist;
    endfunction

    // Pick a distance the block must ignore: no echo, or past the window.
    function automatic logic [DIST_W-1:0] pick_rejected(input logic [DIST_W-1:0] dmax);
        int lo;
        lo = int'(dmax) + ACCEPT_MARGIN_DEF + 1;
        if (lo > 4095 || $urandom_range(0, 2) == 0)
            return '0;
        return DIST_W'($urandom_range(lo, 4095));
    endfunction

    task automatic run_phase(input logic [DIST_W-1:0] dmax);
        int stop_at;
        int kind;
        int ticks;
        write_distance_max(dmax);
        last_dist = DIST_W'($urandom_range(1, 4095));
        stop_at   = items_sent + PHASE_ITEMS;
        while (items_sent < stop_at) begin
            sender_burst = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 39);
            if (kind < 28) begin
                // well-formed: new target, then a ramp toward it
                send_item(ACT_MEASURE, pick_distance(dmax));
                ticks = $urandom_range(1, 24);
            end else if (kind < 32) begin
                // rejected reading in the middle of a ramp
                send_item(ACT_MEASURE, pick_rejected(dmax));
                ticks = $urandom_range(0, 6);
            end else if (kind < 35) begin
                // full-range noise reading, may or may not be taken
                send_item(ACT_MEASURE, DIST_W'($urandom_range(0, 4095)));
                ticks = $urandom_range(0, 6);
            end else if (kind < 39) begin
                ticks = $urandom_range(1, 8);
            end else begin
                // long run: settle the current target, up to the rest of the phase
                ticks = $urandom_range(100, 260);
            end
            // keep the phase at its item budget
            if (ticks > stop_at - items_sent)
                ticks = stop_at - items_sent;
            // tick items carry junk in the distance field
            repeat (ticks) send_item(ACT_TICK, DIST_W'($urandom_range(0, 4095)));
        end
    endtask

    // Result side: stall each item a random time, with stretches of no stall.
    initial begin
        m_tready       = 1'b0;
        receiver_burst = 1'b0;
        @(posedge aclk iff aresetn);
        @(negedge aclk);
        forever begin : take_colors
            int stall;
            if ($urandom_range(0, 15) == 0)
                receiver_burst = !receiver_burst;
            stall = receiver_burst ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tuser      = ACT_MEASURE;
        s_tdata      = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        items_sent   = 0;
        sender_burst = 1'b0;
        last_dist    = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: reset calibration of 200 mm, window up to 225 mm.
        send_item(ACT_TICK, 12'd0);          // idle tick right after reset
        send_item(ACT_MEASURE, 12'd0);       // no echo: target stays 0
        send_item(ACT_TICK, 12'hFFF);        // still idle
        send_item(ACT_MEASURE, 12'd4095);    // far out of window
        send_item(ACT_MEASURE, 12'd225);     // window edge: clamped to full level
        repeat (3) send_item(ACT_TICK, 12'd0);  // level 1 gives green floor of 1
        send_item(ACT_MEASURE, 12'd226);     // one past the window: ignored
        repeat (2) send_item(ACT_TICK, 12'd0);
        send_item(ACT_MEASURE, 12'd30);      // at the floor: target drops to 0 mid-ramp
        repeat (6) send_item(ACT_TICK, 12'd0);  // ramp down, last step flags arrival
        send_item(ACT_MEASURE, 12'd31);      // just above floor still maps to 0
        send_item(ACT_TICK, 12'd0);
        send_item(ACT_MEASURE, 12'd1);       // smallest nonzero reading
        send_item(ACT_MEASURE, 12'd115);     // midpoint of the map
        repeat (3) send_item(ACT_TICK, 12'd0);

        // Random phases over several calibrations, extremes and the
        // degenerate ones at or below the floor included.
        dmax_plan = '{12'd200, 12'd31, 12'd4095, 12'd0, 12'd30, 12'd1000,
                      DIST_W'($urandom_range(31, 4095)), DIST_W'($urandom_range(31, 400))};
        foreach (dmax_plan[i])
            run_phase(dmax_plan[i]);

        // Drop valid, wait out the results, then the block's own latency.
        s_tvalid <= 1'b0;
        while (colors_due != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (fail_count == 0 && colors_due == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
